// ===== src/chrl_pkg.sv =====
// ---------------------------------------------------------------------------
// chrl_pkg - shared types and codes for the hash ring lookup
// item layouts, opcode values, register indexes and sequencer states
// ---------------------------------------------------------------------------
package chrl_pkg;

	localparam int POINT_W  = 32;
	localparam int OWNER_W  = 4;
	localparam int SLOT_W   = 10;
	localparam int PCOUNT_W = 11;
	localparam int SCOUNT_W = 5;
	localparam int COUNT_W  = 32;
	localparam int CFG_W    = 11;

	// opcodes of an input item
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_STATUS = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// configuration register indexes
	localparam logic REG_POINT_COUNT  = 1'b0;
	localparam logic REG_SERVER_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [SLOT_W-1:0]   slot_index;
		logic [POINT_W-1:0]  point_value;
		logic [OWNER_W-1:0]  owner_server;
		logic [OWNER_W-1:0]  server_select;
		logic                online_flag;
		logic [POINT_W-1:0]  key_hash;
	} cmd_t;

	typedef struct packed {
		logic                found;
		logic [OWNER_W-1:0]  server_index;
		logic [COUNT_W-1:0]  hit_count;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMPARE,
		ST_OWNER,
		ST_SCAN,
		ST_HIT,
		ST_RECOUNT
	} state_t;

endpackage

// ===== src/consistent_hash_ring_lookup.sv =====
// ---------------------------------------------------------------------------
// consistent_hash_ring_lookup - sorted point ring with server failover
// binary search over a ring memory, cyclic scan for an online server and
// per-server hit counters, all run by one small sequencer
// ---------------------------------------------------------------------------
//
//  channel   signals                       handshake
//  -------   ---------------------------   ----------------------------------
//  item in   cmd (cmd_t)                   taken when start high, busy low
//  result    result (res_t)                done high for one cycle, no stall
//  config    cfg_we, cfg_index, cfg_wdata  written whenever cfg_we is high
//
//  write and status items: result the cycle after the item is taken, busy
//    stays low, so such items can follow back to back
//  lookup: a binary search of at most ceil(log2(point_count+1)) steps, so at
//    most 11, each a read on the ring memory's single registered read port
//    and a compare, then the owner check and, when the owner is offline or
//    not below server_count, a cyclic failover scan of up to server_count
//    servers (none when no server in use is online), all with busy high; the
//    result comes the cycle after the item is taken on an empty ring
//  a server_count write starts a recount of the online flags, with busy high
//  after reset all servers are online, counters are zero, the ring is empty
//  results cannot be held off: done marks the only cycle they are shown
//
module consistent_hash_ring_lookup
	import chrl_pkg::*;
#(
	parameter int MAX_POINTS  = 1024,
	parameter int MAX_SERVERS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cmd_t             cmd,
	output logic             busy,
	output logic             done,
	output res_t             result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int SW = $clog2(MAX_SERVERS);
	localparam int RW = POINT_W + OWNER_W;

	// ring memory, one write and one registered read port
	logic [RW-1:0]        ring_mem [MAX_POINTS];
	logic [RW-1:0]        ring_rd_q;
	logic [AW-1:0]        rd_addr;
	logic                 ring_we;
	logic [POINT_W-1:0]   rd_point;
	logic [OWNER_W-1:0]   rd_owner;

	// configuration
	logic [PCOUNT_W-1:0]  pcount_q;
	logic [SCOUNT_W-1:0]  scount_q;
	logic [SCOUNT_W-1:0]  scount_wr;

	// server state
	logic [MAX_SERVERS-1:0] online_q;
	logic [COUNT_W-1:0]     hit_cnt_q [MAX_SERVERS];
	logic [SCOUNT_W-1:0]    online_cnt_q, online_cnt_d;

	// sequencer and search registers
	state_t               state_q, state_d;
	logic [PCOUNT_W-1:0]  lo_q, lo_d, hi_q, hi_d;
	logic [PCOUNT_W:0]    mid_sum;
	logic [PCOUNT_W-1:0]  mid;
	logic [PCOUNT_W-1:0]  slot_found;
	logic [POINT_W-1:0]   hash_q, hash_d;
	logic [SCOUNT_W-1:0]  scan_q, scan_d;
	logic [SCOUNT_W-1:0]  step_q, step_d;
	logic [SCOUNT_W-1:0]  who_q, who_d;
	logic [SCOUNT_W-1:0]  scan_next;
	logic [SCOUNT_W-1:0]  owner_next;

	// shared flag read port
	logic [SCOUNT_W-1:0]  flag_idx;
	logic                 flag_in_range;
	logic                 flag_bit;
	logic                 stat_we;

	// hit counter update
	logic                 hit_we;
	logic [SW-1:0]        hc_idx;
	logic [COUNT_W-1:0]   hit_next;

	logic                 accept;
	logic                 done_d;
	res_t                 res_d;
	res_t                 result_q;
	logic                 done_q;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign result   = result_q;

	assign rd_point = ring_rd_q[RW-1:OWNER_W];
	assign rd_owner = ring_rd_q[OWNER_W-1:0];

	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[PCOUNT_W:1];
	// first point at or above the hash, else wrap to entry zero
	assign slot_found = (lo_q >= pcount_q) ? '0 : lo_q;

	// one flag read a cycle; the state picks which server is looked at
	assign flag_in_range = (flag_idx < MAX_SERVERS);
	assign flag_bit      = flag_in_range && online_q[SW'(flag_idx)];

	assign scan_next  = (scan_q + 5'd1 >= scount_q) ? '0 : scan_q + 5'd1;
	assign owner_next = ({1'b0, rd_owner} + 5'd1 >= scount_q) ? '0
		: {1'b0, rd_owner} + 5'd1;

	assign hc_idx   = SW'(who_q);
	assign hit_next = hit_cnt_q[hc_idx] + 32'd1;

	// server_count clamped to 1..MAX_SERVERS
	always_comb begin
		scount_wr = cfg_wdata[SCOUNT_W-1:0];
		if (scount_wr == '0) begin
			scount_wr = 5'd1;
		end else if (scount_wr > MAX_SERVERS) begin
			scount_wr = SCOUNT_W'(MAX_SERVERS);
		end
	end

	// next state and datapath control
	always_comb begin
		state_d      = state_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		hash_d       = hash_q;
		scan_d       = scan_q;
		step_d       = step_q;
		who_d        = who_q;
		online_cnt_d = online_cnt_q;
		done_d       = 1'b0;
		res_d        = '0;
		rd_addr      = AW'(mid);
		flag_idx     = {1'b0, cmd.server_select};
		ring_we      = 1'b0;
		stat_we      = 1'b0;
		hit_we       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.opcode)
						OP_WRITE: begin
							ring_we = (cmd.slot_index < MAX_POINTS);
							done_d  = 1'b1;
						end
						OP_STATUS: begin
							// only a real change moves the online count
							if (flag_in_range && (flag_bit != cmd.online_flag)) begin
								stat_we = 1'b1;
								if (flag_idx < scount_q) begin
									if (cmd.online_flag) begin
										online_cnt_d = online_cnt_q + 5'd1;
									end else if (online_cnt_q != '0) begin
										online_cnt_d = online_cnt_q - 5'd1;
									end
								end
							end
							done_d = 1'b1;
						end
						OP_LOOKUP: begin
							if (pcount_q == '0) begin
								done_d = 1'b1;
							end else begin
								lo_d    = '0;
								hi_d    = pcount_q;
								hash_d  = cmd.key_hash;
								state_d = ST_SEARCH;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (lo_q < hi_q) begin
					state_d = ST_COMPARE;
				end else begin
					rd_addr = AW'(slot_found);
					state_d = ST_OWNER;
				end
			end
			ST_COMPARE: begin
				if (rd_point < hash_q) begin
					lo_d = mid + 11'd1;
				end else begin
					hi_d = mid;
				end
				state_d = ST_SEARCH;
			end
			ST_OWNER: begin
				flag_idx = {1'b0, rd_owner};
				if ((flag_idx < scount_q) && flag_bit) begin
					who_d   = flag_idx;
					state_d = ST_HIT;
				end else if (online_cnt_q == '0) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					scan_d  = owner_next;
					step_d  = '0;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				flag_idx = scan_q;
				if (flag_bit) begin
					who_d   = scan_q;
					state_d = ST_HIT;
				end else if (step_q == scount_q - 5'd1) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					scan_d = scan_next;
					step_d = step_q + 5'd1;
				end
			end
			ST_HIT: begin
				hit_we             = 1'b1;
				done_d             = 1'b1;
				res_d.found        = 1'b1;
				res_d.server_index = who_q[OWNER_W-1:0];
				res_d.hit_count    = hit_next;
				state_d            = ST_IDLE;
			end
			ST_RECOUNT: begin
				flag_idx     = step_q;
				online_cnt_d = online_cnt_q + {4'd0, flag_bit};
				if (step_q == scount_q - 5'd1) begin
					state_d = ST_IDLE;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// a new server count restarts the online recount from server zero
		if (cfg_we && (cfg_index == REG_SERVER_COUNT)) begin
			online_cnt_d = '0;
			step_d       = '0;
			state_d      = ST_RECOUNT;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= 1'b0;
			online_cnt_q <= 5'd1;
			pcount_q     <= '0;
			scount_q     <= 5'd1;
			online_q     <= '1;
		end else begin
			done_q       <= done_d;
			online_cnt_q <= online_cnt_d;
			if (cfg_we && (cfg_index == REG_POINT_COUNT)) begin
				pcount_q <= (cfg_wdata > MAX_POINTS) ? PCOUNT_W'(MAX_POINTS) : cfg_wdata;
			end
			if (cfg_we && (cfg_index == REG_SERVER_COUNT)) begin
				scount_q <= scount_wr;
			end
			if (stat_we) begin
				online_q[SW'(flag_idx)] <= cmd.online_flag;
			end
		end
	end

	// hit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_SERVERS; j++) begin
				hit_cnt_q[j] <= '0;
			end
		end else if (hit_we) begin
			hit_cnt_q[hc_idx] <= hit_next;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		hash_q   <= hash_d;
		scan_q   <= scan_d;
		step_q   <= step_d;
		who_q    <= who_d;
		result_q <= res_d;
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[AW'(cmd.slot_index)] <= {cmd.point_value, cmd.owner_server};
		end
		ring_rd_q <= ring_mem[rd_addr];
	end

	// a found result only ever leaves the counter update
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.found) |-> $past(state_q == ST_HIT))
		else $error("found result without counter update");

	// outside a recount the online count cannot pass the server count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RECOUNT) |-> (online_cnt_q <= scount_q))
		else $error("online count above server count");

	// the failover scan never visits more than server_count servers
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (step_q < scount_q))
		else $error("failover scan overran");

	// a compare cycle always works on a non-empty search window
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPARE) |-> ((lo_q < hi_q) && $stable(lo_q) && $stable(hi_q)))
		else $error("binary search window empty at compare");

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb - self-checking bench for the consistent hash ring lookup
// a queue of pending items and register writes feeds a falling-edge driver;
// a rising-edge monitor keeps its own model of ring, flags and counters,
// predicts each taken item and checks every result against the oldest answer
// ---------------------------------------------------------------------------
module tb;
	import chrl_pkg::*;

	localparam int MAX_PTS    = 1024;
	localparam int MAX_SRV    = 16;
	localparam int QUIET_TAIL = 150;     // last pending entries run without gaps
	localparam int N_MIXED    = 400;     // random items in the mixed part
	localparam int DRAIN      = 64;      // cycles after the last answer

	// opcode with no meaning to the block
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one pending entry: an item for the block or a register write
	typedef struct packed {
		logic             is_cfg;
		logic             cfg_idx;
		logic [CFG_W-1:0] cfg_val;
		cmd_t             item;
	} pend_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	cmd_t             cmd = '0;
	logic             busy;
	logic             done;
	res_t             result;
	logic             cfg_we = 1'b0;
	logic             cfg_index = REG_POINT_COUNT;
	logic [CFG_W-1:0] cfg_wdata = '0;

	pend_t pend_q[$];
	res_t  answer_q[$];
	logic  item_taken = 1'b0;
	int    gap_left = 0;

	// predicted block state
	logic [POINT_W-1:0] pred_point [MAX_PTS];
	logic [OWNER_W-1:0] pred_owner [MAX_PTS];
	bit                 pred_online [MAX_SRV];
	logic [COUNT_W-1:0] pred_hits [MAX_SRV];
	int                 pred_up = 1;
	int                 pred_npoints = 0;
	int                 pred_nservers = 1;

	// run statistics
	int n_fail = 0;
	int n_taken = 0;
	int n_lookups = 0;
	int n_found = 0;
	int n_cfg = 0;

	// stimulus-side view of what the ring holds
	bit                 gen_written [MAX_PTS];
	logic [POINT_W-1:0] gen_val [MAX_PTS];
	int                 gen_pc = 0;
	int                 gen_sc = 1;

	consistent_hash_ring_lookup #(
		.MAX_POINTS(MAX_PTS),
		.MAX_SERVERS(MAX_SRV)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	initial begin
		for (int i = 0; i < MAX_SRV; i++) begin
			pred_online[i] = 1'b1;
			pred_hits[i] = '0;
		end
	end

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------

	// first entry whose point is at or above the hash, wrapping to entry 0
	function automatic int ring_find(logic [POINT_W-1:0] h, int n);
		int lo, hi, mid;
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (pred_point[mid] < h)
				lo = mid + 1;
			else
				hi = mid;
		end
		return (lo >= n) ? 0 : lo;
	endfunction

	function automatic void ring_cfg_apply(logic idx, logic [CFG_W-1:0] d);
		int v;
		if (idx == REG_POINT_COUNT) begin
			v = {21'd0, d};
			pred_npoints = (v > MAX_PTS) ? MAX_PTS : v;
		end else if (idx == REG_SERVER_COUNT) begin
			v = {27'd0, d[SCOUNT_W-1:0]};
			if (v < 1)
				v = 1;
			if (v > MAX_SRV)
				v = MAX_SRV;
			pred_nservers = v;
			// recount the online flags below the new count
			pred_up = 0;
			for (int i = 0; i < pred_nservers; i++)
				if (pred_online[i])
					pred_up++;
		end
	endfunction

	function automatic res_t ring_predict(cmd_t c);
		res_t r;
		int   owner, first, s, who;
		bit   hit;
		r = '0;
		hit = 1'b0;
		who = 0;
		case (c.opcode)
			OP_WRITE: begin
				pred_point[c.slot_index] = c.point_value;
				pred_owner[c.slot_index] = c.owner_server;
			end
			OP_STATUS: begin
				// only a real change moves the online count
				if (pred_online[c.server_select] != c.online_flag) begin
					pred_online[c.server_select] = c.online_flag;
					if (c.server_select < pred_nservers) begin
						if (c.online_flag)
							pred_up++;
						else if (pred_up > 0)
							pred_up--;
					end
				end
			end
			OP_LOOKUP: begin
				if (pred_npoints != 0) begin
					owner = {28'd0, pred_owner[ring_find(c.key_hash, pred_npoints)]};
					if (owner < pred_nservers && pred_online[owner]) begin
						hit = 1'b1;
						who = owner;
					end else if (pred_up != 0) begin
						// failover scan, cyclic over the servers in use
						first = owner + 1;
						if (first >= pred_nservers)
							first = 0;
						for (int k = 0; k < pred_nservers && !hit; k++) begin
							s = first + k;
							if (s >= pred_nservers)
								s -= pred_nservers;
							if (pred_online[s]) begin
								hit = 1'b1;
								who = s;
							end
						end
					end
				end
				if (hit) begin
					pred_hits[who] = pred_hits[who] + 32'd1;
					r.found = 1'b1;
					r.server_index = who[OWNER_W-1:0];
					r.hit_count = pred_hits[who];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// driver: changes inputs on the falling edge, one assignment per signal
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		cmd_t             nxt_cmd;
		logic             nxt_start, nxt_we, nxt_idx;
		logic [CFG_W-1:0] nxt_data;
		pend_t            head;
		nxt_start = start;
		nxt_cmd = cmd;
		nxt_we = 1'b0;
		nxt_idx = cfg_index;
		nxt_data = cfg_wdata;
		if (arst_n) begin
			// item taken at the last rising edge: maybe idle for a burst
			if (start && item_taken) begin
				nxt_start = 1'b0;
				if (pend_q.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 5);
			end
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_q.size() != 0) begin
					head = pend_q[0];
					if (!head.is_cfg) begin
						nxt_start = 1'b1;
						nxt_cmd = head.item;
						void'(pend_q.pop_front());
					end else if (answer_q.size() == 0 && !busy) begin
						// registers only change with the block idle
						nxt_we = 1'b1;
						nxt_idx = head.cfg_idx;
						nxt_data = head.cfg_val;
						void'(pend_q.pop_front());
					end
				end
			end
		end
		start <= nxt_start;
		cmd <= nxt_cmd;
		cfg_we <= nxt_we;
		cfg_index <= nxt_idx;
		cfg_wdata <= nxt_data;
	end

	// ---------------------------------------------------------------------
	// monitor: samples on the rising edge, checks before predicting
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (cfg_we) begin
				ring_cfg_apply(cfg_index, cfg_wdata);
				n_cfg++;
			end
			if (done === 1'b1) begin
				if (answer_q.size() == 0) begin
					$error("result with no item waiting: found %0d server %0d count %0d",
						result.found, result.server_index, result.hit_count);
					n_fail++;
				end else begin
					want = answer_q.pop_front();
					if (result.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, result.found);
						n_fail++;
					end
					if (result.server_index !== want.server_index) begin
						$error("server_index: expected %0d, actual %0d",
							want.server_index, result.server_index);
						n_fail++;
					end
					if (result.hit_count !== want.hit_count) begin
						$error("hit_count: expected %0d, actual %0d",
							want.hit_count, result.hit_count);
						n_fail++;
					end
					if (want.found)
						n_found++;
				end
			end
			if (start && !busy) begin
				answer_q.push_back(ring_predict(cmd));
				n_taken++;
				if (cmd.opcode == OP_LOOKUP)
					n_lookups++;
			end
		end
		item_taken <= arst_n && start && !busy;
	end

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	// every field random, so unused fields toggle too
	function automatic cmd_t rand_cmd(logic [1:0] op);
		cmd_t        c;
		logic [31:0] rnd;
		c.opcode = op;
		rnd = $urandom;
		c.slot_index = rnd[SLOT_W-1:0];
		c.owner_server = rnd[SLOT_W+OWNER_W-1:SLOT_W];
		c.server_select = rnd[SLOT_W+2*OWNER_W-1:SLOT_W+OWNER_W];
		c.online_flag = rnd[31];
		c.point_value = $urandom;
		c.key_hash = $urandom;
		return c;
	endfunction

	function automatic void queue_item(cmd_t c);
		pend_t p;
		p = '0;
		p.item = c;
		pend_q.push_back(p);
	endfunction

	function automatic void queue_cfg(logic idx, int v);
		pend_t p;
		int    w;
		p = '0;
		p.is_cfg = 1'b1;
		p.cfg_idx = idx;
		p.cfg_val = v[CFG_W-1:0];
		pend_q.push_back(p);
		if (idx == REG_POINT_COUNT) begin
			w = v & 32'h7FF;
			gen_pc = (w > MAX_PTS) ? MAX_PTS : w;
		end else begin
			w = v & 32'h1F;
			gen_sc = (w < 1) ? 1 : ((w > MAX_SRV) ? MAX_SRV : w);
		end
	endfunction

	function automatic void queue_write(int slot, logic [31:0] pt, logic [3:0] own);
		cmd_t c;
		c = rand_cmd(OP_WRITE);
		c.slot_index = slot[SLOT_W-1:0];
		c.point_value = pt;
		c.owner_server = own;
		queue_item(c);
		gen_written[slot] = 1'b1;
		gen_val[slot] = pt;
	endfunction

	function automatic cmd_t mk_status(logic [3:0] srv, logic f);
		cmd_t c;
		c = rand_cmd(OP_STATUS);
		c.server_select = srv;
		c.online_flag = f;
		return c;
	endfunction

	function automatic cmd_t mk_lookup(logic [31:0] h);
		cmd_t c;
		c = rand_cmd(OP_LOOKUP);
		c.key_hash = h;
		return c;
	endfunction

	// owner mostly among the servers in use, sometimes beyond them
	function automatic logic [3:0] pick_owner();
		int o;
		if ($urandom_range(0, 4) != 0)
			o = $urandom_range(0, gen_sc - 1);
		else
			o = $urandom_range(0, MAX_SRV - 1);
		return o[3:0];
	endfunction

	// ---------------------------------------------------------------------
	// stimulus, reset and end of run
	// ---------------------------------------------------------------------
	initial begin
		bit [31:0]   vals[$];
		logic [31:0] rnd, key;
		int          n_mixed, phase, r, v, k, srv;
		n_mixed = 0;
		phase = 0;

		// directed: empty ring, then a four-entry ring with both extremes
		queue_item(mk_lookup(32'h0));
		queue_item('1);                          // unused opcode, all fields high
		queue_write(0, 32'h0000_0000, 4'd0);
		queue_write(1, 32'h0000_0100, 4'd1);
		queue_write(2, 32'h8000_0000, 4'd2);
		queue_write(3, 32'hFFFF_FFFF, 4'd15);    // owner beyond the servers in use
		queue_cfg(REG_POINT_COUNT, 4);
		queue_cfg(REG_SERVER_COUNT, 3);
		queue_item(mk_lookup(32'h0000_0000));    // hash zero, first point
		queue_item(mk_lookup(32'h0000_0001));
		queue_item(mk_lookup(32'h0000_0100));    // exactly on a point
		queue_item(mk_lookup(32'h8000_0001));    // out-of-range owner, scan from 0
		queue_item(mk_lookup(32'hFFFF_FFFF));
		queue_item(mk_status(4'd1, 1'b0));
		queue_item(mk_lookup(32'h0000_0050));    // owner offline, fail over
		queue_item(mk_status(4'd1, 1'b0));       // same status again
		queue_item(mk_status(4'd0, 1'b0));
		queue_item(mk_status(4'd2, 1'b0));
		queue_item(mk_lookup(32'h0000_0050));    // nobody online
		queue_item(mk_status(4'd12, 1'b0));      // flag beyond the count
		queue_cfg(REG_SERVER_COUNT, 16);         // recount sees server 12 offline
		queue_item(mk_lookup(32'h8000_0001));
		queue_write(3, 32'hFFFF_FF00, 4'd1);
		queue_item(mk_lookup(32'hFFFF_FFF0));    // above every point, wrap to 0
		queue_item(mk_status(4'd0, 1'b1));
		queue_cfg(REG_SERVER_COUNT, 0);          // clamps to one
		queue_item(mk_lookup(32'h0000_0000));
		queue_cfg(REG_SERVER_COUNT, 31);         // clamps to the maximum

		// random phases, each with its own register setting
		while (n_mixed < N_MIXED) begin
			r = $urandom_range(0, 9);
			case (r)
				0: v = 0;
				1: v = 1;
				2: v = MAX_SRV;
				3: v = $urandom_range(MAX_SRV + 1, 31);
				default: v = $urandom_range(2, MAX_SRV - 1);
			endcase
			queue_cfg(REG_SERVER_COUNT, v);
			r = $urandom_range(0, 15);
			if (phase == 0)
				v = 128;                          // big ring, loaded in full here
			else if (r == 0)
				v = 0;
			else if (r == 1)
				v = $urandom_range(65, 200);
			else
				v = $urandom_range(1, 32);
			queue_cfg(REG_POINT_COUNT, v);

			if (gen_pc > 64) begin
				// big ring: evenly spread sorted base layout
				for (int i = 0; i < gen_pc; i++) begin
					if (!gen_written[i] || i < 64) begin
						rnd = $urandom;
						queue_write(i, {i[7:0], rnd[23:0]}, pick_owner());
					end
				end
			end else begin
				// small ring: random points, some repeated, mostly sorted
				vals.delete();
				for (int i = 0; i < gen_pc; i++) begin
					rnd = $urandom;
					if (i > 0 && $urandom_range(0, 7) == 0)
						rnd = vals[$urandom_range(0, i - 1)];
					vals.push_back(rnd);
				end
				if (gen_pc > 0 && $urandom_range(0, 5) == 0)
					vals[0] = 32'h0;
				if (gen_pc > 1 && $urandom_range(0, 5) == 0)
					vals[gen_pc - 1] = 32'hFFFF_FFFF;
				if ($urandom_range(0, 9) != 0)
					vals.sort();
				for (int i = 0; i < gen_pc; i++)
					queue_write(i, vals[i], pick_owner());
			end

			// mixed traffic: mostly lookups, status flips in between
			for (int j = $urandom_range(20, 50); j > 0; j--) begin
				r = $urandom_range(0, 19);
				if (r < 12) begin
					k = $urandom_range(0, 9);
					if (k == 0)
						key = 32'h0;
					else if (k == 1)
						key = 32'hFFFF_FFFF;
					else if (k < 6 && gen_pc > 0) begin
						// on or next to a loaded point
						key = gen_val[$urandom_range(0, gen_pc - 1)];
						key = key + $urandom_range(0, 2) - 1;
					end else
						key = $urandom;
					queue_item(mk_lookup(key));
				end else if (r < 18) begin
					if ($urandom_range(0, 3) != 0)
						srv = $urandom_range(0, gen_sc - 1);
					else
						srv = $urandom_range(0, MAX_SRV - 1);
					queue_item(mk_status(srv[3:0], 1'($urandom_range(0, 1))));
				end else if (r == 18) begin
					// stray ring write, may break the order
					rnd = $urandom;
					queue_write($urandom_range(0, MAX_PTS - 1), rnd, pick_owner());
				end else begin
					queue_item(rand_cmd(OP_UNUSED));
				end
				n_mixed++;
			end
			phase++;
		end

		// reset once, released on a falling edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// everything handed over, then every answer back, then a quiet spell
		@(posedge clk);
		while (pend_q.size() != 0 || start || cfg_we)
			@(posedge clk);
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d items in %0d random phases: %0d lookups, %0d served",
			n_taken, phase, n_lookups, n_found);
		$display("register writes: %0d, mismatches: %0d", n_cfg, n_fail);
		if (n_fail == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#1500000;
		$display("status: fail");
		$finish;
	end

endmodule
